// ===== hw/rtl/kmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmsd_pkg: shared types and constants of the key matrix scanner
// Matrix geometry, scancode table, item codes and inter-module structs.
// ----------------------------------------------------------------------------
package kmsd_pkg;

  // Matrix geometry and debounce depth
  localparam int ROWS    = 6;
  localparam int COLUMNS = 16;
  localparam int SAMPLES = 2;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // Word fields
  localparam int CODE_W      = 7;
  localparam int SPACE_W     = 7;
  localparam int MAX_RESULTS = 64;
  localparam int COUNT_W     = 7;
  localparam int S_DATA_W    = 16;
  localparam int M_DATA_W    = 16;

  // Item codes
  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_DRAIN     = 1'b1;
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EVENT   = 1'b1;

  // Keys of the reset chord
  localparam int CTRL_ROW       = 3;
  localparam int CTRL_COL       = 15;
  localparam int LEFT_SYS_ROW   = 5;
  localparam int LEFT_SYS_COL   = 14;
  localparam int RIGHT_SYS_ROW  = 5;
  localparam int RIGHT_SYS_COL  = 4;

  // Fixed scancode table
  localparam int TABLE_ROWS = 6;
  localparam int TABLE_COLS = 16;
  localparam logic [CODE_W-1:0] INVALID_CODE = 7'h7F;

  localparam logic [CODE_W-1:0] CODE_ROM [TABLE_ROWS][TABLE_COLS] = '{
    '{7'h2E, 7'h3D, 7'h1D, 7'h1E, 7'h5A, 7'h59, 7'h58, 7'h57,
      7'h56, 7'h55, 7'h54, 7'h53, 7'h52, 7'h51, 7'h50, 7'h45},
    '{7'h46, 7'h41, 7'h0D, 7'h0C, 7'h0B, 7'h0A, 7'h09, 7'h08,
      7'h07, 7'h06, 7'h05, 7'h04, 7'h03, 7'h02, 7'h01, 7'h00},
    '{7'h2F, 7'h5F, 7'h44, 7'h1B, 7'h1A, 7'h19, 7'h18, 7'h17,
      7'h16, 7'h15, 7'h14, 7'h13, 7'h12, 7'h11, 7'h10, 7'h42},
    '{7'h2D, 7'h4C, 7'h2B, 7'h2A, 7'h29, 7'h28, 7'h27, 7'h26,
      7'h25, 7'h24, 7'h23, 7'h22, 7'h21, 7'h20, 7'h62, 7'h63},
    '{7'h4E, 7'h4D, 7'h4F, 7'h61, 7'h3A, 7'h39, 7'h38, 7'h37,
      7'h36, 7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h30, 7'h60},
    '{7'h5E, 7'h3E, 7'h0F, 7'h65, 7'h67, 7'h5B, 7'h3C, 7'h1F,
      7'h3F, 7'h5C, 7'h43, 7'h4A, 7'h5D, 7'h40, 7'h66, 7'h64}
  };

  // Translate a key position, positions outside the table give the invalid code
  function automatic logic [CODE_W-1:0] scancode(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col);
    logic [CODE_W-1:0] code;
    code = INVALID_CODE;
    if (int'(row) < TABLE_ROWS && int'(col) < TABLE_COLS) begin
      code = CODE_ROM[row][col];
    end
    return code;
  endfunction

  typedef logic [ROWS-1:0] row_bits_t;

  // Sequencer to key store
  typedef struct packed {
    logic             tick;
    row_bits_t        levels;
    logic             clear;
    logic             clear_press;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } ks_cmd_t;

  // Key store to sequencer
  typedef struct packed {
    logic [COL_W-1:0] scan_column;
    logic             reset_request;
    logic             pend_press;
    logic             pend_release;
  } ks_status_t;

  // One result word
  typedef struct packed {
    logic              kind;
    logic [COL_W-1:0]  drive_column;
    logic              reset_request;
    logic [CODE_W-1:0] scancode;
    logic              is_press;
    logic              last;
  } out_item_t;

endpackage

// ===== hw/rtl/kmsd_keystore.sv =====
// ----------------------------------------------------------------------------
// kmsd_keystore: debounce samples, key state and pending event bits
// Applies one column update per tick and one event clear per drain step.
// ----------------------------------------------------------------------------
module kmsd_keystore (
  input  logic                 clk,
  input  logic                 rst,
  input  kmsd_pkg::ks_cmd_t    cmd,
  output kmsd_pkg::ks_status_t status
);

  kmsd_pkg::row_bits_t sample_store [kmsd_pkg::COLUMNS][kmsd_pkg::SAMPLES];
  kmsd_pkg::row_bits_t key_state       [kmsd_pkg::COLUMNS];
  kmsd_pkg::row_bits_t press_pending   [kmsd_pkg::COLUMNS];
  kmsd_pkg::row_bits_t release_pending [kmsd_pkg::COLUMNS];
  logic [kmsd_pkg::COL_W-1:0]  scan_column;
  logic [kmsd_pkg::SLOT_W-1:0] sample_slot;

  kmsd_pkg::row_bits_t lvl;
  kmsd_pkg::row_bits_t diff;
  kmsd_pkg::row_bits_t press_next;
  kmsd_pkg::row_bits_t release_next;
  kmsd_pkg::row_bits_t key_next;

  // Debounced level of the scanned column: OR of the new sample and the others
  always_comb begin
    lvl = cmd.levels;
    for (int s = 0; s < kmsd_pkg::SAMPLES; s++) begin
      if (kmsd_pkg::SLOT_W'(s) != sample_slot) begin
        lvl = lvl | sample_store[scan_column][s];
      end
    end
    diff         = key_state[scan_column] ^ lvl;
    press_next   = press_pending[scan_column] | (diff & ~lvl);
    release_next = release_pending[scan_column] | (diff & lvl);
    key_next     = (key_state[scan_column] & ~press_next) | release_next;
  end

  // Update the column on a tick, drop one pending bit on a drain step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < kmsd_pkg::COLUMNS; c++) begin
        for (int s = 0; s < kmsd_pkg::SAMPLES; s++) begin
          sample_store[c][s] <= '1;
        end
        key_state[c]       <= '1;
        press_pending[c]   <= '0;
        release_pending[c] <= '0;
      end
      scan_column <= '0;
      sample_slot <= '0;
    end else begin
      if (cmd.tick) begin
        sample_store[scan_column][sample_slot] <= cmd.levels;
        press_pending[scan_column]   <= press_next;
        release_pending[scan_column] <= release_next;
        key_state[scan_column]       <= key_next;
        if (scan_column == kmsd_pkg::COL_W'(kmsd_pkg::COLUMNS - 1)) begin
          scan_column <= '0;
          if (sample_slot == kmsd_pkg::SLOT_W'(kmsd_pkg::SAMPLES - 1)) begin
            sample_slot <= '0;
          end else begin
            sample_slot <= sample_slot + 1'b1;
          end
        end else begin
          scan_column <= scan_column + 1'b1;
        end
      end
      if (cmd.clear) begin
        if (cmd.clear_press) begin
          press_pending[cmd.col][cmd.row] <= 1'b0;
        end else begin
          release_pending[cmd.col][cmd.row] <= 1'b0;
        end
      end
    end
  end

  assign status.scan_column   = scan_column;
  assign status.reset_request =
      !key_state[kmsd_pkg::CTRL_COL][kmsd_pkg::CTRL_ROW] &&
      !key_state[kmsd_pkg::LEFT_SYS_COL][kmsd_pkg::LEFT_SYS_ROW] &&
      !key_state[kmsd_pkg::RIGHT_SYS_COL][kmsd_pkg::RIGHT_SYS_ROW];
  assign status.pend_press    = press_pending[cmd.col][cmd.row];
  assign status.pend_release  = release_pending[cmd.col][cmd.row];

`ifndef SYNTHESIS
  a_no_tick_during_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.tick && cmd.clear))
    else $error("tick and drain clear in the same cycle");

  a_column_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.tick && scan_column != kmsd_pkg::COL_W'(kmsd_pkg::COLUMNS - 1)
    |=> scan_column == $past(scan_column) + 1'b1)
    else $error("scan column did not advance after tick");
`endif

endmodule

// ===== hw/rtl/kmsd_seq.sv =====
// ----------------------------------------------------------------------------
// kmsd_seq: item sequencer and key walker
// Runs the tick update; walks key positions on drain, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module kmsd_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  kmsd_pkg::row_bits_t                 row_levels,
  input  logic [kmsd_pkg::SPACE_W-1:0]        buffer_space,
  input  kmsd_pkg::ks_status_t                status,
  output kmsd_pkg::ks_cmd_t                   cmd,
  input  logic                                out_ready,
  output logic                                push,
  output kmsd_pkg::out_item_t                 push_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_OUT,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t                         state;
  logic [kmsd_pkg::COL_W-1:0]     col;
  logic [kmsd_pkg::ROW_W-1:0]     row;
  logic [kmsd_pkg::COUNT_W-1:0]   budget;
  logic [kmsd_pkg::COUNT_W-1:0]   count;
  logic                           have_cand;
  kmsd_pkg::out_item_t            cand;
  kmsd_pkg::row_bits_t            levels;

  logic                           key_event;
  logic                           full;
  logic                           at_end;
  kmsd_pkg::out_item_t            new_item;
  kmsd_pkg::out_item_t            status_item;
  logic [kmsd_pkg::COUNT_W-1:0]   space_clamped;

  assign key_event = status.pend_press || status.pend_release;
  assign full      = (count == budget);
  assign at_end    = (col == kmsd_pkg::COL_W'(kmsd_pkg::COLUMNS - 1)) &&
                     (row == kmsd_pkg::ROW_W'(kmsd_pkg::ROWS - 1));
  assign in_ready  = (state == S_IDLE);

  assign space_clamped =
      (buffer_space > kmsd_pkg::SPACE_W'(kmsd_pkg::MAX_RESULTS)) ?
      kmsd_pkg::COUNT_W'(kmsd_pkg::MAX_RESULTS) :
      kmsd_pkg::COUNT_W'(buffer_space);

  // Build the event word for the current key and the tick status word
  always_comb begin
    new_item               = '0;
    new_item.kind          = kmsd_pkg::KIND_EVENT;
    new_item.scancode      = kmsd_pkg::scancode(row, col);
    new_item.is_press      = status.pend_press;
    status_item               = '0;
    status_item.kind          = kmsd_pkg::KIND_STATUS;
    status_item.drive_column  = status.scan_column;
    status_item.reset_request = status.reset_request;
    status_item.last          = 1'b1;
  end

  // Key store commands
  always_comb begin
    cmd             = '0;
    cmd.tick        = (state == S_TICK);
    cmd.levels      = levels;
    cmd.col         = col;
    cmd.row         = row;
    cmd.clear       = (state == S_WALK) && out_ready && !full && key_event;
    cmd.clear_press = status.pend_press;
  end

  // Push finished words; a candidate leaves once the next event or the end is known
  always_comb begin
    push      = 1'b0;
    push_item = cand;
    unique case (state)
      S_TICK_OUT: begin
        push      = out_ready;
        push_item = status_item;
      end
      S_WALK: begin
        if (out_ready) begin
          if (full) begin
            push           = 1'b1;
            push_item.last = 1'b1;
          end else if (key_event && have_cand) begin
            push           = 1'b1;
            push_item.last = 1'b0;
          end
        end
      end
      S_FLUSH: begin
        push           = out_ready && have_cand;
        push_item.last = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_cand <= 1'b0;
      col       <= '0;
      row       <= '0;
      budget    <= '0;
      count     <= '0;
      cand      <= '0;
      levels    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (op == kmsd_pkg::OP_TICK) begin
              levels <= row_levels;
              state  <= S_TICK;
            end else begin
              budget    <= space_clamped;
              count     <= '0;
              col       <= '0;
              row       <= '0;
              have_cand <= 1'b0;
              state     <= (space_clamped == '0) ? S_IDLE : S_WALK;
            end
          end
        end
        S_TICK: begin
          state <= S_TICK_OUT;
        end
        S_TICK_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (out_ready) begin
            if (full) begin
              state <= S_IDLE;
            end else begin
              if (key_event) begin
                cand      <= new_item;
                have_cand <= 1'b1;
                count     <= count + 1'b1;
              end
              // Advance to the next row, then the next column
              if (at_end) begin
                state <= S_FLUSH;
              end else if (row == kmsd_pkg::ROW_W'(kmsd_pkg::ROWS - 1)) begin
                row <= '0;
                col <= col + 1'b1;
              end else begin
                row <= row + 1'b1;
              end
            end
          end
        end
        S_FLUSH: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_in_budget: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> count <= budget)
    else $error("drain sent more events than the buffer space");

  a_full_has_cand: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && full |-> have_cand)
    else $error("drain budget used up without a held event");
`endif

endmodule

// ===== hw/rtl/key_matrix_scan_debounce.sv =====
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce: 6x16 key matrix scanner with debounce
// Tick words update one column; drain words emit pending key scancodes.
// ----------------------------------------------------------------------------
// A tick updates the key store in S_TICK and pushes its status word in S_TICK_OUT;
// inputs are taken again in S_IDLE. A drain walks 96 key positions one per cycle
// while the output is not stalled, then flushes the held event; it ends early once
// the space runs out. One word at a time; the walk is paced by the output register.
// Reset: synchronous, sets key and sample state to released, clears pending state.
// ----------------------------------------------------------------------------
module key_matrix_scan_debounce (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [5:0] row_levels, [12:6] buffer_space, [15:13] zero
  input  logic [15:0] s_tdata,
  // [0] operation
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] drive_column, [4] reset_request, [11:5] scancode, [12] is_press,
  // [15:13] zero
  output logic [15:0] m_tdata,
  // [0] kind
  output logic        m_tuser,
  output logic        m_tlast
);

  kmsd_pkg::ks_cmd_t    cmd;
  kmsd_pkg::ks_status_t status;
  logic                 out_ready;
  logic                 push;
  kmsd_pkg::out_item_t  push_item;
  logic                 out_valid;
  kmsd_pkg::out_item_t  out_item;

  kmsd_keystore u_keystore (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status)
  );

  kmsd_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .op           (s_tuser),
    .row_levels   (s_tdata[5:0]),
    .buffer_space (s_tdata[12:6]),
    .status       (status),
    .cmd          (cmd),
    .out_ready    (out_ready),
    .push         (push),
    .push_item    (push_item)
  );

  // Output register: load when empty or being taken
  assign out_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= push_item;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_item.kind;
  assign m_tlast  = out_item.last;
  assign m_tdata  = {3'b000, out_item.is_press, out_item.scancode,
                     out_item.reset_request, out_item.drive_column};

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_ready)
    else $error("word pushed into a full output register");
`endif

endmodule
